### src/xx_pkg.sv
package xx_pkg;

	localparam int WORD_W     = 32;
	localparam int KEY_WORDS  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int ROUND_BASE = 6;
	localparam int ROUND_NUM  = 52;

	localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;
	localparam logic [WORD_W-1:0] KEY_RESET = 32'hFFFF_FFFF;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [KEY_WORDS-1:0] key_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t KEY_WORD_0 = 3'd0;
	localparam cfg_idx_t KEY_WORD_1 = 3'd1;
	localparam cfg_idx_t KEY_WORD_2 = 3'd2;
	localparam cfg_idx_t KEY_WORD_3 = 3'd3;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PREP0,
		ST_PREP1,
		ST_RUN,
		ST_EMIT_RD,
		ST_EMIT_SHOW
	} state_t;

endpackage

### src/xx_plain_if.sv
interface xx_plain_if;
	logic        valid;
	logic        ready;
	logic [31:0] plain_word;

	modport source (output valid, output plain_word, input ready);
	modport sink   (input valid, input plain_word, output ready);
endinterface

### src/xx_cipher_if.sv
interface xx_cipher_if;
	logic        valid;
	logic        ready;
	logic [31:0] cipher_word;
	logic        final_word;

	modport source (output valid, output cipher_word, output final_word, input ready);
	modport sink   (input valid, input cipher_word, input final_word, output ready);
endinterface

### src/xx_ram.sv
module xx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

### src/xx_key_regs.sv
module xx_key_regs import xx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  cfg_idx_t cfg_idx,
	input  word_t    cfg_data,
	output key_t     keys
);
	key_t keys_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= {KEY_WORDS{KEY_RESET}};
		end else if (cfg_we) begin
			case (cfg_idx)
				KEY_WORD_0: keys_q[0] <= cfg_data;
				KEY_WORD_1: keys_q[1] <= cfg_data;
				KEY_WORD_2: keys_q[2] <= cfg_data;
				KEY_WORD_3: keys_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign keys = keys_q;
endmodule

### src/xx_round_unit.sv
module xx_round_unit import xx_pkg::*; (
	input  word_t z,
	input  word_t y,
	input  word_t v,
	input  word_t sum,
	input  word_t k,
	output word_t z_new
);
	word_t t1;
	word_t t2;

	assign t1    = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
	assign t2    = (sum ^ y) + (k ^ z);
	assign z_new = v + (t1 ^ t2);
endmodule

### src/xxtea_block_encrypt.sv
// After the last word of a block is taken, two prepare states read the first two words,
// then R = 6 + 52/N rounds run with one word update per cycle through the shared round unit;
// each cipher word is then read from the block store and shown until the sink takes it.
// Input is accepted only while loading; one block is in flight at a time.
// Reset clears the sequencer and word counters and sets all key words to ones;
// the block store holds no reset value.
module xxtea_block_encrypt import xx_pkg::*; #(
	parameter int BLOCK_WORDS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  cfg_idx_t cfg_idx,
	input  word_t    cfg_data,
	xx_plain_if.sink    plain,
	xx_cipher_if.source cipher
);
	localparam int IW     = $clog2(BLOCK_WORDS);
	localparam int ROUNDS = ROUND_BASE + ROUND_NUM / BLOCK_WORDS;
	localparam int RW     = $clog2(ROUNDS);

	localparam logic [IW-1:0] IDX_LAST   = IW'(BLOCK_WORDS - 1);
	localparam logic [RW-1:0] ROUND_LAST = RW'(ROUNDS - 1);
	localparam logic [IW:0]   NWORDS     = (IW+1)'(BLOCK_WORDS);

	state_t          state_q, state_d;
	logic [IW-1:0]   idx_q;
	logic [RW-1:0]   round_q;
	logic            byp_q;
	word_t           z_q, v_q, sum_q;

	key_t            keys;
	word_t           k_sel, y, z_new, rdata;
	logic [1:0]      k_idx;
	logic [IW:0]     nxt2_raw;
	logic [IW-1:0]   nxt2;
	logic            idx_last, round_last;

	logic            ram_we, ram_re;
	logic [IW-1:0]   ram_waddr, ram_raddr;
	word_t           ram_wdata;
	logic            load_xfer, out_xfer;

	xx_key_regs u_keys (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.keys     (keys)
	);

	xx_ram #(.WIDTH(WORD_W), .DEPTH(BLOCK_WORDS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	assign idx_last   = (idx_q == IDX_LAST);
	assign round_last = (round_q == ROUND_LAST);
	assign k_idx      = 2'(idx_q) ^ sum_q[3:2];
	assign k_sel      = keys[k_idx];
	assign y          = byp_q ? z_q : rdata;
	assign nxt2_raw   = {1'b0, idx_q} + (IW+1)'(2);
	assign nxt2       = (nxt2_raw >= NWORDS) ? IW'(nxt2_raw - NWORDS) : IW'(nxt2_raw);

	xx_round_unit u_round (
		.z     (z_q),
		.y     (y),
		.v     (v_q),
		.sum   (sum_q),
		.k     (k_sel),
		.z_new (z_new)
	);

	assign load_xfer = plain.valid && plain.ready;
	assign out_xfer  = cipher.valid && cipher.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:      if (load_xfer && idx_last) state_d = ST_PREP0;
			ST_PREP0:     state_d = ST_PREP1;
			ST_PREP1:     state_d = ST_RUN;
			ST_RUN:       if (idx_last && round_last) state_d = ST_EMIT_RD;
			ST_EMIT_RD:   state_d = ST_EMIT_SHOW;
			ST_EMIT_SHOW: begin
				if (out_xfer)
					state_d = idx_last ? ST_LOAD : ST_EMIT_RD;
			end
			default:      state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		plain.ready  = 1'b0;
		cipher.valid = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = idx_q;
		ram_wdata    = z_new;
		ram_re       = 1'b0;
		ram_raddr    = idx_q;
		case (state_q)
			ST_LOAD: begin
				plain.ready = 1'b1;
				ram_we      = load_xfer;
				ram_wdata   = plain.plain_word;
			end
			ST_PREP0: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			ST_PREP1: begin
				ram_re    = 1'b1;
				ram_raddr = IW'(1);
			end
			ST_RUN: begin
				ram_we    = 1'b1;
				ram_re    = 1'b1;
				ram_raddr = nxt2;
			end
			ST_EMIT_RD: begin
				ram_re = 1'b1;
			end
			ST_EMIT_SHOW: begin
				cipher.valid = 1'b1;
			end
			default: ;
		endcase
	end

	assign cipher.cipher_word = rdata;
	assign cipher.final_word  = idx_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			idx_q   <= '0;
			round_q <= '0;
			byp_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (load_xfer)
						idx_q <= idx_last ? '0 : idx_q + 1'b1;
				end
				ST_PREP0: begin
					round_q <= '0;
					byp_q   <= 1'b0;
				end
				ST_RUN: begin
					// read of the word after next collides with this write for two-word blocks
					byp_q <= (nxt2 == idx_q);
					idx_q <= idx_last ? '0 : idx_q + 1'b1;
					if (idx_last)
						round_q <= round_q + 1'b1;
				end
				ST_EMIT_SHOW: begin
					if (out_xfer)
						idx_q <= idx_last ? '0 : idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (load_xfer)
					z_q <= plain.plain_word;
			end
			ST_PREP0: begin
				sum_q <= DELTA;
			end
			ST_PREP1: begin
				v_q <= rdata;
			end
			ST_RUN: begin
				z_q <= z_new;
				v_q <= y;
				if (idx_last)
					sum_q <= sum_q + DELTA;
			end
			default: ;
		endcase
	end
endmodule
